// ===== design/lorentz_force_magnitude_sum_macros.svh =====
// assertion macros used by the lorentz force sum top level
// no dependencies; included by the top level, which carries concurrent checks
`ifndef LORENTZ_FORCE_MAGNITUDE_SUM_MACROS_SVH
`define LORENTZ_FORCE_MAGNITUDE_SUM_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LFMS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define LFMS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lfms_pkg.sv =====
`timescale 1ns / 1ps
// shared constants for the lorentz force magnitude sum block
// no dependencies
package lfms_pkg;

  localparam int MAX_DIM_DEF    = 32;
  localparam int FIELD_BITS_DEF = 24;

  localparam int SIZE_BITS    = 6;
  localparam int COND_BITS    = 24;
  localparam int CFG_BITS     = 24;
  localparam int CFG_IDX_BITS = 2;
  localparam int TOTAL_BITS   = 64;

  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Z = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COND   = 2'd3;

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 6'd32;

endpackage

// ===== design/lorentz_force_magnitude_sum.sv =====
`timescale 1ns / 1ps
// top level: raster cell ring, curl x B force magnitude, saturating sum
// uses lfms_pkg, lfms_ring, lfms_isqrt and the assertion macros
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in      | input     | in_valid/in_ready  | in_field_x/y/z (signed Q8.16)
//   out     | output    | out_valid/out_ready| out_force_total, out_overflowed
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a border cell only goes through accept and position update
// an interior cell goes on to six ring reads, fifteen passes through the one shared
//   multiplier, the bit-serial square root (one bit per cycle) and two scaling
//   multiplies
// reset is synchronous, active low; the ring holds no reset, reads only touch
//   cells written in the current grid
// the last cell of a grid waits in its final step while an earlier total is
//   still held in the output register
`include "lorentz_force_magnitude_sum_macros.svh"
module lorentz_force_magnitude_sum #(
  parameter int MAX_DIM    = lfms_pkg::MAX_DIM_DEF,
  parameter int FIELD_BITS = lfms_pkg::FIELD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [FIELD_BITS-1:0]      in_field_x,
  input  logic signed [FIELD_BITS-1:0]      in_field_y,
  input  logic signed [FIELD_BITS-1:0]      in_field_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lfms_pkg::TOTAL_BITS-1:0]   out_force_total,
  output logic                              out_overflowed,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lfms_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [lfms_pkg::CFG_BITS-1:0]     cfg_data
);

  // widths derived from the field width
  localparam int IN_DROP   = (FIELD_BITS > 28) ? (FIELD_BITS - 28) : 0;
  localparam int W         = FIELD_BITS - IN_DROP;     // stored component width
  localparam int OUT_SHIFT = 33 - 2 * IN_DROP;
  localparam int CW        = W + 2;                    // doubled curl
  localparam int LW        = 2 * W + 3;                // doubled force component
  localparam int HW        = (LW + 1) / 2;             // low half for squaring
  localparam int RW        = LW + 1;                   // root width
  localparam int SW        = 2 * RW;                   // sum of squares
  localparam int MH        = (RW + 1) / 2;             // low half of the root
  localparam int CB        = lfms_pkg::COND_BITS;
  localparam int TB        = lfms_pkg::TOTAL_BITS;
  localparam int OPW0      = (CW > HW + 1) ? CW : HW + 1;
  localparam int OPW1      = (OPW0 > MH + 1) ? OPW0 : MH + 1;
  localparam int OPW       = (OPW1 > CB + 1) ? OPW1 : CB + 1;
  localparam int PW        = 2 * OPW;
  localparam int CPW       = CB + RW;

  // ring and position widths
  localparam int DEPTH = 4 * MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int PB    = $clog2(MAX_DIM);
  localparam int DB    = $clog2(MAX_DIM + 1);
  localparam int SB    = lfms_pkg::SIZE_BITS;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_CURL = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_SQGO = 3'd4;
  localparam logic [2:0] ST_SQ   = 3'd5;
  localparam logic [2:0] ST_ACC  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  // multiplier op slots
  localparam logic [4:0] OP_SQ_END = 5'd15;   // last consume before the root
  localparam logic [4:0] OP_SC0    = 5'd16;   // conductivity * low root half
  localparam logic [4:0] OP_SC1    = 5'd17;   // conductivity * high root half
  localparam logic [4:0] OP_END    = 5'd18;

  // neighbor slots
  localparam logic [2:0] NB_C  = 3'd0;
  localparam logic [2:0] NB_XM = 3'd1;
  localparam logic [2:0] NB_YP = 3'd2;
  localparam logic [2:0] NB_YM = 3'd3;
  localparam logic [2:0] NB_ZP = 3'd4;
  localparam logic [2:0] NB_ZM = 3'd5;
  localparam logic [2:0] NB_N  = 3'd6;

  logic [2:0] state_r, state_nxt;

  // configuration
  logic [SB-1:0] size_x_r, size_y_r, size_z_r;
  logic [CB-1:0] cond_r;
  logic [DB-1:0] sx, sy, sz;
  logic [2*DB-1:0] plane;

  // grid position and ring slot of the current cell
  logic [PB-1:0] pos_slow_r, pos_mid_r, pos_fast_r;
  logic [AW-1:0] wslot_r;
  logic [TB-1:0] total_r;
  logic          sat_r;

  // output register
  logic          out_valid_r;
  logic [TB-1:0] out_total_r;
  logic          out_ovf_r;

  // working registers
  logic signed [W-1:0]  cur_y_r, cur_z_r;
  logic signed [W-1:0]  nbx_r [NB_N];
  logic signed [W-1:0]  nby_r [NB_N];
  logic signed [W-1:0]  nbz_r [NB_N];
  logic [2:0]           rd_cnt_r;
  logic [4:0]           op_r;
  logic signed [CW-1:0] c2x_r, c2y_r, c2z_r;
  logic signed [LW-1:0] t_r, lx_r, ly_r, lz_r;
  logic signed [PW-1:0] prod_r;
  logic [SW-1:0]        sum_r;
  logic [CPW-1:0]       cp_r;

  logic          in_acc, cfg_acc, size_wr;
  logic          interior, is_last, emit;
  logic [AW:0]   off, diff;
  logic [AW-1:0] raddr;
  logic [3*W-1:0] wdata, rdata;
  logic signed [OPW-1:0] mul_a, mul_b;
  logic [LW-1:0]  sel_mag;
  logic           sq_done;
  logic [RW-1:0]  sq_root;
  logic [TB-1:0]  force_q;
  logic [TB:0]    add_sum;

  // clamp size registers: zero acts as 1, anything above MAX_DIM as MAX_DIM
  function automatic logic [DB-1:0] clamp_size(input logic [SB-1:0] v);
    logic [DB-1:0] r;
    if (v == '0) begin
      r = DB'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DB'(MAX_DIM);
    end else begin
      r = DB'(v);
    end
    return r;
  endfunction

  function automatic logic [LW-1:0] mag(input logic signed [LW-1:0] v);
    return v[LW-1] ? LW'(-v) : LW'(v);
  endfunction

  assign sx    = clamp_size(size_x_r);
  assign sy    = clamp_size(size_y_r);
  assign sz    = clamp_size(size_z_r);
  assign plane = (2*DB)'(sy) * (2*DB)'(sz);

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign size_wr   = cfg_acc && (cfg_index != lfms_pkg::REG_COND);

  // interior test on the position of the cell just taken
  assign interior = (pos_slow_r >= PB'(2)) && (pos_mid_r >= PB'(1)) &&
                    ((DB+1)'(pos_mid_r) + (DB+1)'(2) <= (DB+1)'(sy)) &&
                    (pos_fast_r >= PB'(1)) &&
                    ((DB+1)'(pos_fast_r) + (DB+1)'(2) <= (DB+1)'(sz));

  assign is_last = ((DB+1)'(pos_slow_r) + (DB+1)'(1) >= (DB+1)'(sx)) &&
                   ((DB+1)'(pos_mid_r) + (DB+1)'(1) >= (DB+1)'(sy)) &&
                   ((DB+1)'(pos_fast_r) + (DB+1)'(1) >= (DB+1)'(sz));

  assign emit = (state_r == ST_FIN) && is_last && (!out_valid_r || out_ready);

  // ring: the new cell is written as it is accepted, input already floor-shifted
  assign wdata = {in_field_z[FIELD_BITS-1:IN_DROP], in_field_y[FIELD_BITS-1:IN_DROP],
                  in_field_x[FIELD_BITS-1:IN_DROP]};

  // distance back from the current slot for each neighbor
  always_comb begin
    case (rd_cnt_r)
      NB_C:    off = (AW+1)'(plane);
      NB_XM:   off = (AW+1)'(plane) << 1;
      NB_YP:   off = (AW+1)'(plane) - (AW+1)'(sz);
      NB_YM:   off = (AW+1)'(plane) + (AW+1)'(sz);
      NB_ZP:   off = (AW+1)'(plane) - (AW+1)'(1);
      NB_ZM:   off = (AW+1)'(plane) + (AW+1)'(1);
      default: off = '0;
    endcase
    diff  = {1'b0, wslot_r} - off;
    raddr = diff[AW] ? AW'(diff + (AW+1)'(DEPTH)) : AW'(diff);
  end

  lfms_ring #(
    .DEPTH (DEPTH),
    .DW    (3 * W)
  ) u_ring (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wslot_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  lfms_isqrt #(
    .RW (RW)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_SQGO),
    .radicand (sum_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  // magnitude feeding the squaring ops
  always_comb begin
    case (op_r) inside
      [5'd6:5'd8]:   sel_mag = mag(lx_r);
      [5'd9:5'd11]:  sel_mag = mag(ly_r);
      default:       sel_mag = mag(lz_r);
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    case (op_r)
      5'd0:  begin mul_a = OPW'(c2y_r); mul_b = OPW'(nbz_r[NB_C]); end
      5'd1:  begin mul_a = OPW'(c2z_r); mul_b = OPW'(nby_r[NB_C]); end
      5'd2:  begin mul_a = OPW'(c2z_r); mul_b = OPW'(nbx_r[NB_C]); end
      5'd3:  begin mul_a = OPW'(c2x_r); mul_b = OPW'(nbz_r[NB_C]); end
      5'd4:  begin mul_a = OPW'(c2x_r); mul_b = OPW'(nby_r[NB_C]); end
      5'd5:  begin mul_a = OPW'(c2y_r); mul_b = OPW'(nbx_r[NB_C]); end
      5'd6, 5'd9, 5'd12: begin
        mul_a = OPW'(sel_mag[LW-1:HW]);
        mul_b = OPW'(sel_mag[LW-1:HW]);
      end
      5'd7, 5'd10, 5'd13: begin
        mul_a = OPW'(sel_mag[LW-1:HW]);
        mul_b = OPW'(sel_mag[HW-1:0]);
      end
      5'd8, 5'd11, 5'd14: begin
        mul_a = OPW'(sel_mag[HW-1:0]);
        mul_b = OPW'(sel_mag[HW-1:0]);
      end
      OP_SC0: begin mul_a = OPW'(cond_r); mul_b = OPW'(sq_root[MH-1:0]); end
      OP_SC1: begin mul_a = OPW'(cond_r); mul_b = OPW'(sq_root[RW-1:MH]); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign force_q = TB'(cp_r >> OUT_SHIFT);
  assign add_sum = {1'b0, total_r} + {1'b0, force_q};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = interior ? ST_READ : ST_FIN;
      ST_READ: if (rd_cnt_r == NB_N) state_nxt = ST_CURL;
      ST_CURL: state_nxt = ST_MUL;
      ST_MUL: begin
        if (op_r == OP_SQ_END) begin
          state_nxt = ST_SQGO;
        end else if (op_r == OP_END) begin
          state_nxt = ST_ACC;
        end
      end
      ST_SQGO: state_nxt = ST_SQ;
      ST_SQ:   if (sq_done) state_nxt = ST_MUL;
      ST_ACC:  state_nxt = ST_FIN;
      ST_FIN:  if (!is_last || emit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_x_r    <= lfms_pkg::SIZE_RESET;
      size_y_r    <= lfms_pkg::SIZE_RESET;
      size_z_r    <= lfms_pkg::SIZE_RESET;
      cond_r      <= '0;
      pos_slow_r  <= '0;
      pos_mid_r   <= '0;
      pos_fast_r  <= '0;
      wslot_r     <= '0;
      total_r     <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      rd_cnt_r    <= '0;
      op_r        <= '0;
    end else begin
      state_r <= state_nxt;

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_acc) begin
        unique case (cfg_index)
          lfms_pkg::REG_SIZE_X: size_x_r <= cfg_data[SB-1:0];
          lfms_pkg::REG_SIZE_Y: size_y_r <= cfg_data[SB-1:0];
          lfms_pkg::REG_SIZE_Z: size_z_r <= cfg_data[SB-1:0];
          lfms_pkg::REG_COND:   cond_r   <= cfg_data[CB-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        rd_cnt_r <= '0;
        op_r     <= '0;
      end

      if (state_r == ST_READ) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end

      if (state_r == ST_MUL) begin
        op_r <= op_r + 1'b1;
      end
      if (state_r == ST_SQ && sq_done) begin
        op_r <= OP_SC0;
      end

      // saturating sum of the cell force
      if (state_r == ST_ACC) begin
        if (add_sum[TB]) begin
          total_r <= '1;
          sat_r   <= 1'b1;
        end else begin
          total_r <= add_sum[TB-1:0];
        end
      end

      if (state_r == ST_FIN) begin
        if (is_last) begin
          if (emit) begin
            out_valid_r <= 1'b1;
            pos_slow_r  <= '0;
            pos_mid_r   <= '0;
            pos_fast_r  <= '0;
            wslot_r     <= '0;
            total_r     <= '0;
            sat_r       <= 1'b0;
          end
        end else begin
          wslot_r <= (wslot_r == AW'(DEPTH - 1)) ? '0 : wslot_r + 1'b1;
          if ((DB+1)'(pos_fast_r) + (DB+1)'(1) >= (DB+1)'(sz)) begin
            pos_fast_r <= '0;
            if ((DB+1)'(pos_mid_r) + (DB+1)'(1) >= (DB+1)'(sy)) begin
              pos_mid_r  <= '0;
              pos_slow_r <= pos_slow_r + 1'b1;
            end else begin
              pos_mid_r <= pos_mid_r + 1'b1;
            end
          end else begin
            pos_fast_r <= pos_fast_r + 1'b1;
          end
        end
      end

      // a size write restarts the grid
      if (size_wr) begin
        pos_slow_r <= '0;
        pos_mid_r  <= '0;
        pos_fast_r <= '0;
        wslot_r    <= '0;
        total_r    <= '0;
        sat_r      <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_y_r <= in_field_y[FIELD_BITS-1:IN_DROP];
      cur_z_r <= in_field_z[FIELD_BITS-1:IN_DROP];
    end

    // ring read data is registered and belongs to the previous read address
    if (state_r == ST_READ && rd_cnt_r != NB_C) begin
      nbx_r[rd_cnt_r - 1'b1] <= rdata[W-1:0];
      nby_r[rd_cnt_r - 1'b1] <= rdata[2*W-1:W];
      nbz_r[rd_cnt_r - 1'b1] <= rdata[3*W-1:2*W];
    end

    // doubled curl by central differences, +x neighbor is the new cell
    if (state_r == ST_CURL) begin
      c2x_r <= CW'(nbz_r[NB_YP]) - CW'(nbz_r[NB_YM]) - CW'(nby_r[NB_ZP]) + CW'(nby_r[NB_ZM]);
      c2y_r <= CW'(nbx_r[NB_ZP]) - CW'(nbx_r[NB_ZM]) - CW'(cur_z_r) + CW'(nbz_r[NB_XM]);
      c2z_r <= CW'(cur_y_r) - CW'(nby_r[NB_XM]) - CW'(nbx_r[NB_YP]) + CW'(nbx_r[NB_YM]);
    end

    if (state_r == ST_MUL) begin
      prod_r <= mul_a * mul_b;
      // consume the product of the previous op
      case (op_r)
        5'd1, 5'd3, 5'd5: t_r <= LW'(prod_r);
        5'd2:  lx_r <= LW'(t_r - prod_r);
        5'd4:  ly_r <= LW'(t_r - prod_r);
        5'd6:  lz_r <= LW'(t_r - prod_r);
        5'd7:  sum_r <= SW'($unsigned(prod_r)) << (2 * HW);
        5'd10, 5'd13: sum_r <= sum_r + (SW'($unsigned(prod_r)) << (2 * HW));
        5'd8, 5'd11, 5'd14: sum_r <= sum_r + (SW'($unsigned(prod_r)) << (HW + 1));
        5'd9, 5'd12, OP_SQ_END: sum_r <= sum_r + SW'($unsigned(prod_r));
        OP_SC1: cp_r <= CPW'($unsigned(prod_r));
        OP_END: cp_r <= cp_r + (CPW'($unsigned(prod_r)) << MH);
        default: ;
      endcase
    end

    if (emit) begin
      out_total_r <= total_r;
      out_ovf_r   <= sat_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_force_total = out_total_r;
  assign out_overflowed  = out_ovf_r;

  `LFMS_ASSERT_IMP(a_sqrt_in_wait, clk, rst_n, sq_done, state_r == ST_SQ, "root done outside wait")
  `LFMS_ASSERT_NXT(a_emit_loads, clk, rst_n, emit, out_valid_r, "grid total not presented")
  `LFMS_ASSERT_IMP(a_sat_total, clk, rst_n, out_valid_r && out_ovf_r, &out_total_r, "flag without saturated total")
  `LFMS_ASSERT_NXT(a_accept_busy, clk, rst_n, in_acc, state_r != ST_IDLE, "accepted item left no work")

endmodule

// ===== design/lfms_ring.sv =====
`timescale 1ns / 1ps
// cell ring: one write port, one registered read port
// no dependencies
module lfms_ring #(
  parameter int DEPTH = 4096,
  parameter int DW    = 72
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lfms_isqrt.sv =====
`timescale 1ns / 1ps
// iterative integer square root, one root bit per cycle
// no dependencies
module lfms_isqrt #(
  parameter int RW = 52
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*RW-1:0] radicand,
  output logic            done,
  output logic [RW-1:0]   root
);

  localparam int CB = $clog2(RW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CB-1:0]   cnt_r;
  logic [2*RW-1:0] rad_r;
  logic [RW+1:0]   rem_r;
  logic [RW-1:0]   root_r;

  logic [RW+3:0]   tmp;
  logic [RW+3:0]   trial;

  assign tmp   = {rem_r, rad_r[2*RW-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CB'(RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CB'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= rad_r << 2;
      if (tmp >= trial) begin
        rem_r  <= (RW+2)'(tmp - trial);
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= (RW+2)'(tmp);
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== tb/lorentz_force_magnitude_sum_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for lorentz_force_magnitude_sum: raster grids of field
// cells in, one saturating force total out per grid; depends on lfms_pkg and the rtl

typedef struct {
  bit [63:0] total;
  bit        ovf;
} grid_total_t;

// tracks the field ring and the running sum, and holds the totals still owed
class force_sum_board;
  localparam int RING = 4 * lfms_pkg::MAX_DIM_DEF * lfms_pkg::MAX_DIM_DEF;
  longint      ring_x[RING], ring_y[RING], ring_z[RING];
  int          slot, p_slow, p_mid, p_fast;
  bit [63:0]   sum;
  bit          sat;
  bit [5:0]    ext_x, ext_y, ext_z;
  bit [23:0]   cond;
  grid_total_t owed[$];
  int          errors, cells, totals_seen;

  function new();
    ext_x = 6'd32;
    ext_y = 6'd32;
    ext_z = 6'd32;
    cond = 0;
    restart();
  endfunction

  function void restart();
    slot = 0;
    p_slow = 0;
    p_mid = 0;
    p_fast = 0;
    sum = 0;
    sat = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [23:0] v);
    case (idx)
      lfms_pkg::REG_SIZE_X: begin
        ext_x = v[5:0];
        restart();
      end
      lfms_pkg::REG_SIZE_Y: begin
        ext_y = v[5:0];
        restart();
      end
      lfms_pkg::REG_SIZE_Z: begin
        ext_z = v[5:0];
        restart();
      end
      default: cond = v;
    endcase
  endfunction

  function int clamp(bit [5:0] v);
    if (v == 0) return 1;
    return (v > lfms_pkg::MAX_DIM_DEF) ? lfms_pkg::MAX_DIM_DEF : int'(v);
  endfunction

  function int back(int off);
    return (slot + RING - off % RING) % RING;
  endfunction

  function bit [127:0] square(longint v);
    bit [63:0] a;
    a = (v < 0) ? -v : v;
    return {64'b0, a} * {64'b0, a};
  endfunction

  // doubled curl crossed with the center cell, exact root, scaled by conductivity
  function bit [63:0] cell_force(int sz, int plane);
    int         c, xp, xm, yp, ym, zp, zm;
    longint     cx, cy, cz, lx, ly, lz;
    bit [127:0] s, p;
    bit [63:0]  m, t;
    c = back(plane);
    xp = back(0);
    xm = back(2 * plane);
    yp = back(plane - sz);
    ym = back(plane + sz);
    zp = back(plane - 1);
    zm = back(plane + 1);
    cx = (ring_z[yp] - ring_z[ym]) - (ring_y[zp] - ring_y[zm]);
    cy = (ring_x[zp] - ring_x[zm]) - (ring_z[xp] - ring_z[xm]);
    cz = (ring_y[xp] - ring_y[xm]) - (ring_x[yp] - ring_x[ym]);
    lx = cy * ring_z[c] - cz * ring_y[c];
    ly = cz * ring_x[c] - cx * ring_z[c];
    lz = cx * ring_y[c] - cy * ring_x[c];
    s = square(lx) + square(ly) + square(lz);
    m = 0;
    for (int b = 63; b >= 0; b--) begin
      t = m | (64'd1 << b);
      if ({64'b0, t} * {64'b0, t} <= s) m = t;
    end
    p = {104'b0, cond} * {64'b0, m};
    return p[96:33];
  endfunction

  function void note_input(logic signed [23:0] fx, logic signed [23:0] fy,
                           logic signed [23:0] fz);
    int          sx, sy, sz;
    bit [63:0]   f;
    grid_total_t e;
    sx = clamp(ext_x);
    sy = clamp(ext_y);
    sz = clamp(ext_z);
    cells++;
    ring_x[slot] = fx;
    ring_y[slot] = fy;
    ring_z[slot] = fz;
    if (p_slow >= 2 && p_mid >= 1 && p_mid + 2 <= sy && p_fast >= 1 && p_fast + 2 <= sz) begin
      f = cell_force(sz, sy * sz);
      if (sum > 64'hFFFF_FFFF_FFFF_FFFF - f) begin
        sum = 64'hFFFF_FFFF_FFFF_FFFF;
        sat = 1;
      end else begin
        sum += f;
      end
    end
    if (p_slow + 1 >= sx && p_mid + 1 >= sy && p_fast + 1 >= sz) begin
      e.total = sum;
      e.ovf = sat;
      owed.push_back(e);
      restart();
      return;
    end
    slot = (slot + 1) % RING;
    if (p_fast + 1 >= sz) begin
      p_fast = 0;
      if (p_mid + 1 >= sy) begin
        p_mid = 0;
        p_slow++;
      end else begin
        p_mid++;
      end
    end else begin
      p_fast++;
    end
  endfunction

  function void check_result(bit [63:0] tot, bit ovf);
    grid_total_t e;
    totals_seen++;
    if (owed.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected total %0d ovf %0b", tot, ovf);
      return;
    end
    e = owed.pop_front();
    if (e.total !== tot || e.ovf !== ovf) begin
      errors++;
      if (errors <= 10)
        $display("total mismatch: expected %0d ovf %0b, got %0d ovf %0b",
                 e.total, e.ovf, tot, ovf);
    end
  endfunction
endclass

module lorentz_force_magnitude_sum_tb;
  localparam int FB     = lfms_pkg::FIELD_BITS_DEF;
  localparam int SETTLE = 200;

  logic                             clk = 0;
  logic                             rst_n = 0;
  logic                             in_valid = 0;
  logic                             in_ready;
  logic signed [FB-1:0]             in_field_x = 0, in_field_y = 0, in_field_z = 0;
  logic                             out_valid;
  logic                             out_ready = 0;
  logic [lfms_pkg::TOTAL_BITS-1:0]  out_force_total;
  logic                             out_overflowed;
  logic                             cfg_valid = 0;
  logic                             cfg_ready;
  logic [lfms_pkg::CFG_IDX_BITS-1:0] cfg_index = 0;
  logic [lfms_pkg::CFG_BITS-1:0]    cfg_data = 0;

  force_sum_board sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int grids = 0;

  lorentz_force_magnitude_sum uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // result side: check accepted totals, random stalls, long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) sb.check_result(out_force_total, out_overflowed);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("lorentz_force_magnitude_sum regression: fail");
    $finish;
  end

  // extremes often, small values sometimes, otherwise any 24-bit pattern
  function logic [FB-1:0] pick_field();
    case ($urandom_range(9))
      0: return {1'b0, {(FB-1){1'b1}}};
      1: return {1'b1, {(FB-1){1'b0}}};
      2: return FB'($signed($urandom_range(511)) - 256);
      default: return FB'($urandom);
    endcase
  endfunction

  task automatic send_cell(logic [FB-1:0] fx, logic [FB-1:0] fy, logic [FB-1:0] fz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_field_x <= fx;
    in_field_y <= fy;
    in_field_z <= fz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(fx, fy, fz);
  endtask

  // let every owed total come back, then give the block time to go quiet
  task automatic drain();
    in_valid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [23:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic setup_grid(bit [5:0] sx, bit [5:0] sy, bit [5:0] sz, bit [23:0] c);
    drain();
    write_cfg(lfms_pkg::REG_COND, c);
    write_cfg(lfms_pkg::REG_SIZE_X, 24'(sx));
    write_cfg(lfms_pkg::REG_SIZE_Y, 24'(sy));
    write_cfg(lfms_pkg::REG_SIZE_Z, 24'(sz));
    cfg_valid <= 0;
  endtask

  task automatic send_grid(int n);
    for (int i = 0; i < n; i++) send_cell(pick_field(), pick_field(), pick_field());
    grids++;
  endtask

  task automatic random_grid();
    bit [5:0]  s[3];
    bit [23:0] c;
    int        n;
    for (int a = 0; a < 3; a++) s[a] = 6'($urandom_range(1, 6));
    // odd extents now and then: zero, one, two or at or past the maximum
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: s[$urandom_range(2)] = 6'd0;
        1: s[$urandom_range(2)] = 6'($urandom_range(1, 2));
        default: begin
          s[0] = 6'd3;
          s[1] = 6'd3;
          s[2] = 6'd3;
          s[$urandom_range(2)] = 6'($urandom_range(32, 63));
        end
      endcase
    end
    case ($urandom_range(3))
      0: c = 24'd0;
      1: c = 24'hFFFFFF;
      default: c = 24'($urandom);
    endcase
    setup_grid(s[0], s[1], s[2], c);
    n = sb.clamp(s[0]) * sb.clamp(s[1]) * sb.clamp(s[2]);
    send_grid(n);
  endtask

  initial begin
    logic [FB-1:0] ext[5];
    int            stall_set[4], idle_set[4];
    ext[0] = {1'b0, {(FB-1){1'b1}}};
    ext[1] = {1'b1, {(FB-1){1'b0}}};
    ext[2] = '0;
    ext[3] = '1;
    ext[4] = FB'(1);
    idle_set = '{0, 64, 0, 6};
    stall_set = '{0, 0, 64, 6};
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: 3x3x3 grid of extreme values at full conductivity
    setup_grid(6'd3, 6'd3, 6'd3, 24'hFFFFFF);
    for (int i = 0; i < 27; i++)
      send_cell(ext[i % 5], ext[(i / 5) % 5], ext[(i * 3 + 1) % 5]);
    grids++;
    // zero conductivity must give zero, flat grids give zero
    setup_grid(6'd3, 6'd3, 6'd3, 24'd0);
    send_grid(27);
    setup_grid(6'd0, 6'd63, 6'd2, 24'h123456);
    send_grid(64);

    // size write in the middle of a grid restarts it
    setup_grid(6'd4, 6'd4, 6'd4, 24'h00FFFF);
    for (int i = 0; i < 10; i++) send_cell(pick_field(), pick_field(), pick_field());
    setup_grid(6'd3, 6'd4, 6'd3, 24'h010000);
    send_grid(36);

    // receiver holds off long; one total is held, the next grid stalls in its last cell
    setup_grid(6'd3, 6'd3, 6'd3, 24'hABCDEF);
    hold_left = 3000;
    for (int g = 0; g < 4; g++) send_grid(27);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_set[p];
      recv_stall_pct = stall_set[p];
      while (sb.cells < 300 + 340 * (p + 1)) random_grid();
    end

    drain();
    if (sb.owed.size() != 0) sb.errors += sb.owed.size();
    $display("covered %0d cells in %0d grids, %0d totals checked, %0d mismatches",
             sb.cells, grids, sb.totals_seen, sb.errors);
    $display("phases: no idling, sender idle, receiver stall, both, plus a long hold-off");
    if (sb.errors == 0) begin
      $display("lorentz_force_magnitude_sum regression: pass");
    end else begin
      $display("lorentz_force_magnitude_sum regression: fail");
    end
    $finish;
  end
endmodule

// ===== lorentz_force_magnitude_sum.f =====
+incdir+design
design/lfms_pkg.sv
design/lfms_ring.sv
design/lfms_isqrt.sv
design/lorentz_force_magnitude_sum.sv
tb/lorentz_force_magnitude_sum_tb.sv
